// ===== rtl/bqmf_pkg.sv =====
package bqmf_pkg;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_MOVE    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // Source that a cell loads from.
  typedef enum logic [2:0] {
    SEL_HOLD,
    SEL_LOAD,
    SEL_RIGHT,
    SEL_LEFT,
    SEL_MOVED
  } sel_t;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned PORT_W   = 32;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned COUNT_W  = 5;

endpackage

// ===== rtl/bqmf_cell.sv =====
module bqmf_cell #(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic                         clk,
  input  bqmf_pkg::sel_t               sel,
  input  logic signed [WORD_WIDTH-1:0] load_word,
  input  logic signed [WORD_WIDTH-1:0] left_word,
  input  logic signed [WORD_WIDTH-1:0] right_word,
  input  logic signed [WORD_WIDTH-1:0] moved_word,
  output logic signed [WORD_WIDTH-1:0] word,
  output logic signed [WORD_WIDTH-1:0] word_next
);

  always_comb begin
    case (sel)
      bqmf_pkg::SEL_LOAD:  word_next = load_word;
      bqmf_pkg::SEL_RIGHT: word_next = right_word;
      bqmf_pkg::SEL_LEFT:  word_next = left_word;
      bqmf_pkg::SEL_MOVED: word_next = moved_word;
      default:             word_next = word;
    endcase
  end

  // Payload only: unwritten cells are never reported.
  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

// ===== rtl/bounded_queue_move_nth_front.sv =====
// The response beat of an accepted command is registered and valid in the cycle after.
// Throughput: one command per cycle while the response register can take it;
// every command, move-to-front included, completes as one step because all cells of the row shift together.
// A new command is taken whenever the response register is empty or drained.
// Reset (rst, synchronous, active high) empties the queue and drops any
// pending response; cell contents are left as they are and never reported.
module bounded_queue_move_nth_front #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cmd_valid,
  output logic                                  cmd_ready,
  input  logic [bqmf_pkg::CMD_W-1:0]            cmd,
  input  logic signed [bqmf_pkg::PORT_W-1:0]    value,
  input  logic [bqmf_pkg::POS_W-1:0]            position,
  output logic                                  rsp_valid,
  input  logic                                  rsp_ready,
  output logic [bqmf_pkg::STATUS_W-1:0]         status,
  output logic signed [bqmf_pkg::PORT_W-1:0]    front_value,
  output logic signed [bqmf_pkg::PORT_W-1:0]    back_value,
  output logic [bqmf_pkg::COUNT_W-1:0]          count,
  output logic                                  is_empty,
  output logic                                  is_full
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  // Wide enough to compare a position against the fill count.
  localparam int unsigned PW = (CW > bqmf_pkg::POS_W) ? CW : bqmf_pkg::POS_W;

  // The row keeps entries in queue order: cell 0 is the front.
  logic signed [WORD_WIDTH-1:0] cell_word [CAPACITY];
  logic signed [WORD_WIDTH-1:0] cell_next [CAPACITY];
  bqmf_pkg::sel_t               cell_sel  [CAPACITY];

  logic [CW-1:0] fill;
  logic [CW-1:0] fill_next;
  logic          accept;
  logic          is_full_now;
  logic          is_empty_now;
  logic          pos_ok;
  logic          do_enq;
  logic          do_deq;
  logic          do_move;
  bqmf_pkg::status_t status_next;

  logic signed [63:0]           value_ext;
  logic signed [WORD_WIDTH-1:0] load_word;
  logic signed [WORD_WIDTH-1:0] moved_word;
  logic signed [WORD_WIDTH-1:0] back_word;
  logic [IW-1:0]                moved_idx;
  logic [IW-1:0]                back_idx;
  logic [CW-1:0]                fill_less;
  logic [PW-1:0]                pos_w;
  logic [PW-1:0]                fill_w;

  // A new beat enters whenever the response register is free or draining.
  assign cmd_ready = !rsp_valid || rsp_ready;
  assign accept    = cmd_valid && cmd_ready;

  assign is_full_now  = (fill == CW'(CAPACITY));
  assign is_empty_now = (fill == '0);

  // Keep the value to the word width with its sign.
  assign value_ext = 64'(value);
  assign load_word = value_ext[WORD_WIDTH-1:0];

  assign pos_w  = PW'(position);
  assign fill_w = PW'(fill);
  assign pos_ok = (pos_w >= PW'(2)) && (pos_w <= fill_w);

  // Decode the command and the status it earns.
  always_comb begin
    do_enq      = 1'b0;
    do_deq      = 1'b0;
    do_move     = 1'b0;
    status_next = bqmf_pkg::ST_DONE;
    case (bqmf_pkg::cmd_t'(cmd))
      bqmf_pkg::CMD_ENQUEUE: begin
        if (is_full_now) status_next = bqmf_pkg::ST_FULL;
        else             do_enq      = accept;
      end
      bqmf_pkg::CMD_DEQUEUE: begin
        if (is_empty_now) status_next = bqmf_pkg::ST_EMPTY;
        else              do_deq      = accept;
      end
      bqmf_pkg::CMD_MOVE: begin
        if (!pos_ok) status_next = bqmf_pkg::ST_BADPOS;
        else         do_move     = accept;
      end
      default: begin
        // Unused command: change nothing and report done.
        status_next = bqmf_pkg::ST_DONE;
      end
    endcase
  end

  always_comb begin
    fill_next = fill;
    if (do_enq) fill_next = fill + CW'(1);
    if (do_deq) fill_next = fill - CW'(1);
  end

  // The entry picked for the front; only read when the position is valid.
  assign moved_idx  = IW'(position - bqmf_pkg::POS_W'(1));
  assign moved_word = cell_word[moved_idx];

  // Build the row: each cell sees its neighbors and the broadcast words.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [WORD_WIDTH-1:0] left_w;
    logic signed [WORD_WIDTH-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = cell_word[0];
    end else begin : g_inner_l
      assign left_w = cell_word[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = cell_word[i];
    end else begin : g_inner_r
      assign right_w = cell_word[i+1];
    end

    always_comb begin
      cell_sel[i] = bqmf_pkg::SEL_HOLD;
      if (do_enq && (fill == CW'(i))) begin
        cell_sel[i] = bqmf_pkg::SEL_LOAD;
      end else if (do_deq) begin
        cell_sel[i] = bqmf_pkg::SEL_RIGHT;
      end else if (do_move) begin
        if (i == 0)                       cell_sel[i] = bqmf_pkg::SEL_MOVED;
        else if (PW'(i) < pos_w)          cell_sel[i] = bqmf_pkg::SEL_LEFT;
      end
    end

    bqmf_cell #(
      .WORD_WIDTH(WORD_WIDTH)
    ) u_cell (
      .clk        (clk),
      .sel        (cell_sel[i]),
      .load_word  (load_word),
      .left_word  (left_w),
      .right_word (right_w),
      .moved_word (moved_word),
      .word       (cell_word[i]),
      .word_next  (cell_next[i])
    );
  end

  // Report the queue as it stands after the command.
  assign fill_less = fill_next - CW'(1);
  assign back_idx  = IW'(fill_less);
  assign back_word = cell_next[back_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Hold the response payload until the next accepted beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      status   <= status_next;
      count    <= bqmf_pkg::COUNT_W'(fill_next);
      is_empty <= (fill_next == '0);
      is_full  <= (fill_next == CW'(CAPACITY));
      if (fill_next == '0) begin
        front_value <= '1;
        back_value  <= '1;
      end else begin
        front_value <= bqmf_pkg::PORT_W'(64'(cell_next[0]));
        back_value  <= bqmf_pkg::PORT_W'(64'(back_word));
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(CAPACITY))
    else $error("fill count beyond capacity");

  a_deq_step: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == bqmf_pkg::CMD_DEQUEUE && fill != '0)
      |=> (fill == $past(fill) - CW'(1)))
    else $error("dequeue did not drop one entry");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (accept && status_next == bqmf_pkg::ST_FULL) |-> is_full_now)
    else $error("full status on a queue with room");

  a_rsp_flags: assert property (@(posedge clk) disable iff (rst)
    $past(accept) |-> (is_empty == (fill == '0)))
    else $error("empty flag disagrees with fill count");

endmodule
